### src/swvg_pkg.sv
`timescale 1ns / 1ps

package swvg_pkg;

  localparam int VAR_W      = 47;
  localparam int LEN_W      = 7;
  localparam int LIMIT_W    = 24;
  localparam int RATIO_W    = 10;
  localparam int FILL_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GNSS_VAR_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ODOM_VAR_RATIO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GNSS_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ODOM_ENABLE    = 3'd4;

  localparam logic [LEN_W-1:0]   RST_WINDOW_LEN     = 7'd50;
  localparam logic [LIMIT_W-1:0] RST_GNSS_VAR_LIMIT = 24'd6554;
  localparam logic [RATIO_W-1:0] RST_ODOM_VAR_RATIO = 10'd100;

  localparam logic SRC_GNSS = 1'b0;
  localparam logic SRC_ODOM = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]   window_len;
    logic [LIMIT_W-1:0] gnss_var_limit;
    logic [RATIO_W-1:0] odom_var_ratio;
    logic               gnss_enable;
    logic               odom_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic ev_rd;
    logic sq_ev;
    logic sq_in;
    logic acc_sub;
    logic acc_add;
    logic var_mul;
    logic var_diff;
    logic div_step;
    logic judge;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic enabled;
    logic evict_need;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

### src/swvg_in_if.sv
`timescale 1ns / 1ps

interface swvg_in_if #(parameter int POS_WIDTH = 24);
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;

  modport source (output valid, cmd, pos_x, pos_y, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, output ready);
endinterface

### src/swvg_out_if.sv
`timescale 1ns / 1ps

interface swvg_out_if;
  logic                                valid;
  logic                                ready;
  logic                                source_kind;
  logic                                accepted;
  logic                                window_ok;
  logic [swvg_pkg::VAR_W-1:0]          var_x_out;
  logic [swvg_pkg::VAR_W-1:0]          var_y_out;
  logic [swvg_pkg::FILL_W-1:0]         fill_count;

  modport source (output valid, source_kind, accepted, window_ok, var_x_out, var_y_out,
                  fill_count, input ready);
  modport sink (input valid, source_kind, accepted, window_ok, var_x_out, var_y_out,
                fill_count, output ready);
endinterface

### src/swvg_cfg_if.sv
`timescale 1ns / 1ps

interface swvg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [swvg_pkg::CFG_IDX_W-1:0]    index;
  logic [swvg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/swvg_ram.sv
`timescale 1ns / 1ps

module swvg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/swvg_ctrl.sv
`timescale 1ns / 1ps

module swvg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swvg_pkg::dp_status_t status,
  output swvg_pkg::dp_cmd_t    cmd
);
  import swvg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_EV_RD, S_EV_SQ, S_EV_SUB, S_INS_SQ, S_INS_ADD,
    S_VMUL, S_VDIFF, S_DIV, S_JUDGE, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!status.enabled) begin
          state_nxt = S_JUDGE;
        end else if (status.evict_need) begin
          state_nxt = S_EV_RD;
        end else begin
          state_nxt = S_INS_SQ;
        end
      end
      S_EV_RD: begin
        cmd.ev_rd = 1'b1;
        state_nxt = S_EV_SQ;
      end
      S_EV_SQ: begin
        cmd.sq_ev = 1'b1;
        state_nxt = S_EV_SUB;
      end
      S_EV_SUB: begin
        cmd.acc_sub = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_INS_SQ: begin
        cmd.sq_in = 1'b1;
        state_nxt = S_INS_ADD;
      end
      S_INS_ADD: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_VMUL;
      end
      S_VMUL: begin
        cmd.var_mul = 1'b1;
        state_nxt   = S_VDIFF;
      end
      S_VDIFF: begin
        cmd.var_diff = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        cmd.judge = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/swvg_dp.sv
`timescale 1ns / 1ps

module swvg_dp #(
  parameter int WINDOW_DEPTH = 64,
  parameter int POS_WIDTH    = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swvg_pkg::cfg_t                 cfg,
  input  swvg_pkg::dp_cmd_t              cmd,
  output swvg_pkg::dp_status_t           status,
  input  logic                           in_cmd,
  input  logic signed [POS_WIDTH-1:0]    in_pos_x,
  input  logic signed [POS_WIDTH-1:0]    in_pos_y,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_source_kind,
  output logic                           out_accepted,
  output logic                           out_window_ok,
  output logic [swvg_pkg::VAR_W-1:0]     out_var_x,
  output logic [swvg_pkg::VAR_W-1:0]     out_var_y,
  output logic [swvg_pkg::FILL_W-1:0]    out_fill_count
);
  import swvg_pkg::*;

  localparam int P     = POS_WIDTH;
  localparam int CNTW  = $clog2(WINDOW_DEPTH + 1);
  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int SW    = P + CNTW;
  localparam int SQW   = 2 * P + CNTW;
  localparam int NW    = (2 * SW > CNTW + SQW) ? 2 * SW : CNTW + SQW;
  localparam int DW    = 2 * CNTW;
  localparam int RW    = DW + 1;
  localparam int QW    = (NW > VAR_W) ? NW : VAR_W + 1;
  localparam int LW    = (CNTW > LEN_W) ? CNTW : LEN_W;
  localparam int PW    = RATIO_W + VAR_W;
  localparam int DCW   = $clog2(NW);
  localparam int RAM_D = 2 * (2 ** AW);

  function automatic logic [P-1:0] mag_pos(input logic signed [P-1:0] v);
    mag_pos = v[P-1] ? P'(-v) : P'(v);
  endfunction

  function automatic logic [SW-1:0] mag_sum(input logic signed [SW-1:0] v);
    mag_sum = v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  logic                  src_r;
  logic signed [P-1:0]   px_r, py_r;
  logic [CNTW-1:0]       cnt_r [2];
  logic [AW-1:0]         head_r [2];
  logic signed [SW-1:0]  s1x_r [2];
  logic signed [SW-1:0]  s1y_r [2];
  logic [SQW-1:0]        s2x_r [2];
  logic [SQW-1:0]        s2y_r [2];
  logic [VAR_W-1:0]      gv0_r, gv1_r;
  logic signed [P-1:0]   ax_r, ay_r;
  logic [2*P-1:0]        sqx_r, sqy_r;
  logic [NW-1:0]         numx_r, numy_r, sqsx_r, sqsy_r;
  logic [DW-1:0]         dd_r;
  logic [PW-1:0]         prod0_r, prod1_r;
  logic [NW-1:0]         qx_r, qy_r;
  logic [RW-1:0]         remx_r, remy_r;
  logic [DCW-1:0]        dcnt_r;
  logic                  res_acc_r, res_ok_r;
  logic [VAR_W-1:0]      res_vx_r, res_vy_r;
  logic [FILL_W-1:0]     res_fill_r;
  logic                  out_valid_r;
  logic                  out_src_r, out_acc_r, out_ok_r;
  logic [VAR_W-1:0]      out_vx_r, out_vy_r;
  logic [FILL_W-1:0]     out_fill_r;

  logic [CNTW-1:0]       cnt_cur;
  logic [AW-1:0]         head_cur, head_inc, oldest;
  logic [CNTW:0]         old_tmp;
  logic [LW-1:0]         len_ext, eff_len;
  logic [2*P-1:0]        rdata;
  logic signed [P-1:0]   rx, ry, smp_x, smp_y;
  logic [P-1:0]          mx, my;
  logic [CNTW+SQW-1:0]   nsx, nsy;
  logic [SW-1:0]         m1x, m1y;
  logic [2*SW-1:0]       ssx, ssy;
  logic [DW-1:0]         dd;
  logic [PW-1:0]         prod0, prod1;
  logic [RW-1:0]         shx, shy;
  logic                  gex, gey;
  logic [QW-1:0]         qxe, qye;
  logic [VAR_W-1:0]      vx, vy;
  logic                  ok;

  assign cnt_cur  = cnt_r[src_r];
  assign head_cur = head_r[src_r];
  assign head_inc = (head_cur == AW'(WINDOW_DEPTH - 1)) ? '0 : head_cur + 1'b1;

  always_comb begin
    old_tmp = (CNTW+1)'(head_cur) + (CNTW+1)'(WINDOW_DEPTH) - (CNTW+1)'(cnt_cur);
    if (old_tmp >= (CNTW+1)'(WINDOW_DEPTH)) begin
      old_tmp = old_tmp - (CNTW+1)'(WINDOW_DEPTH);
    end
    oldest = old_tmp[AW-1:0];
  end

  always_comb begin
    len_ext = LW'(cfg.window_len);
    priority if (len_ext == '0) begin
      eff_len = LW'(1);
    end else if (len_ext > LW'(WINDOW_DEPTH)) begin
      eff_len = LW'(WINDOW_DEPTH);
    end else begin
      eff_len = len_ext;
    end
  end

  assign status.enabled    = (src_r == SRC_ODOM) ? cfg.odom_enable : cfg.gnss_enable;
  assign status.evict_need = LW'(cnt_cur) >= eff_len;
  assign status.div_last   = dcnt_r == DCW'(NW - 1);
  assign status.out_free   = !out_valid_r || out_ready;

  swvg_ram #(.WIDTH(2 * P), .DEPTH(RAM_D)) u_ram (
    .clk   (clk),
    .wr_en (cmd.sq_in),
    .waddr ({src_r, head_cur}),
    .wdata ({py_r, px_r}),
    .rd_en (cmd.ev_rd),
    .raddr ({src_r, oldest}),
    .rdata (rdata)
  );

  assign rx    = rdata[P-1:0];
  assign ry    = rdata[2*P-1:P];
  assign smp_x = cmd.sq_ev ? rx : px_r;
  assign smp_y = cmd.sq_ev ? ry : py_r;
  assign mx    = mag_pos(smp_x);
  assign my    = mag_pos(smp_y);

  assign nsx   = cnt_cur * s2x_r[src_r];
  assign nsy   = cnt_cur * s2y_r[src_r];
  assign m1x   = mag_sum(s1x_r[src_r]);
  assign m1y   = mag_sum(s1y_r[src_r]);
  assign ssx   = m1x * m1x;
  assign ssy   = m1y * m1y;
  assign dd    = cnt_cur * cnt_cur;
  assign prod0 = cfg.odom_var_ratio * gv0_r;
  assign prod1 = cfg.odom_var_ratio * gv1_r;

  assign shx = {remx_r[RW-2:0], qx_r[NW-1]};
  assign shy = {remy_r[RW-2:0], qy_r[NW-1]};
  assign gex = shx >= RW'(dd_r);
  assign gey = shy >= RW'(dd_r);

  always_comb begin
    qxe = QW'(qx_r);
    qye = QW'(qy_r);
    vx  = (qxe > QW'(VAR_MAX)) ? VAR_MAX : qxe[VAR_W-1:0];
    vy  = (qye > QW'(VAR_MAX)) ? VAR_MAX : qye[VAR_W-1:0];
    if (src_r == SRC_GNSS) begin
      ok = (vx <= VAR_W'(cfg.gnss_var_limit)) && (vy <= VAR_W'(cfg.gnss_var_limit));
    end else begin
      ok = !((gv0_r != '0) && (gv1_r != '0) &&
             ((PW'(vx) > prod0_r) || (PW'(vy) > prod1_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
        s1x_r[i]  <= '0;
        s1y_r[i]  <= '0;
        s2x_r[i]  <= '0;
        s2y_r[i]  <= '0;
      end
      gv0_r       <= '0;
      gv1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc_sub) begin
        s1x_r[src_r] <= s1x_r[src_r] - {{CNTW{ax_r[P-1]}}, ax_r};
        s1y_r[src_r] <= s1y_r[src_r] - {{CNTW{ay_r[P-1]}}, ay_r};
        s2x_r[src_r] <= s2x_r[src_r] - SQW'(sqx_r);
        s2y_r[src_r] <= s2y_r[src_r] - SQW'(sqy_r);
        cnt_r[src_r] <= cnt_cur - 1'b1;
      end
      if (cmd.acc_add) begin
        s1x_r[src_r]  <= s1x_r[src_r] + {{CNTW{ax_r[P-1]}}, ax_r};
        s1y_r[src_r]  <= s1y_r[src_r] + {{CNTW{ay_r[P-1]}}, ay_r};
        s2x_r[src_r]  <= s2x_r[src_r] + SQW'(sqx_r);
        s2y_r[src_r]  <= s2y_r[src_r] + SQW'(sqy_r);
        cnt_r[src_r]  <= cnt_cur + 1'b1;
        head_r[src_r] <= head_inc;
      end
      if (cmd.judge && status.enabled && src_r == SRC_GNSS) begin
        gv0_r <= vx;
        gv1_r <= vy;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= in_cmd;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
    end
    if (cmd.sq_ev || cmd.sq_in) begin
      ax_r  <= smp_x;
      ay_r  <= smp_y;
      sqx_r <= mx * mx;
      sqy_r <= my * my;
    end
    if (cmd.var_mul) begin
      numx_r  <= NW'(nsx);
      numy_r  <= NW'(nsy);
      sqsx_r  <= NW'(ssx);
      sqsy_r  <= NW'(ssy);
      dd_r    <= dd;
      prod0_r <= prod0;
      prod1_r <= prod1;
    end
    if (cmd.var_diff) begin
      qx_r   <= (numx_r > sqsx_r) ? numx_r - sqsx_r : '0;
      qy_r   <= (numy_r > sqsy_r) ? numy_r - sqsy_r : '0;
      remx_r <= '0;
      remy_r <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      remx_r <= gex ? shx - RW'(dd_r) : shx;
      remy_r <= gey ? shy - RW'(dd_r) : shy;
      qx_r   <= {qx_r[NW-2:0], gex};
      qy_r   <= {qy_r[NW-2:0], gey};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.judge) begin
      res_fill_r <= FILL_W'(cnt_cur);
      if (status.enabled) begin
        res_acc_r <= 1'b1;
        res_ok_r  <= ok;
        res_vx_r  <= vx;
        res_vy_r  <= vy;
      end else begin
        res_acc_r <= 1'b0;
        res_ok_r  <= 1'b0;
        res_vx_r  <= '0;
        res_vy_r  <= '0;
      end
    end
    if (cmd.out_load) begin
      out_src_r  <= src_r;
      out_acc_r  <= res_acc_r;
      out_ok_r   <= res_ok_r;
      out_vx_r   <= res_vx_r;
      out_vy_r   <= res_vy_r;
      out_fill_r <= res_fill_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_source_kind = out_src_r;
  assign out_accepted    = out_acc_r;
  assign out_window_ok   = out_ok_r;
  assign out_var_x       = out_vx_r;
  assign out_var_y       = out_vy_r;
  assign out_fill_count  = out_fill_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CNTW'(WINDOW_DEPTH)) && (cnt_r[1] <= CNTW'(WINDOW_DEPTH)))
    else $error("window fill beyond depth");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_sub |-> (cnt_cur != '0))
    else $error("eviction from empty window");
`endif

endmodule

### src/sliding_window_variance_gate.sv
`timescale 1ns / 1ps
// Each input transaction evicts the oldest samples while the window is full, inserts the
// new sample, forms the variance terms and divides before its result goes valid.
// Throughput: one transaction at a time, a new one accepted once the result is loaded
// into the output register; the bit-serial divide (one quotient bit per cycle for x and y
// together) dominates. A disabled source skips the window update and the divide.
// Reset: synchronous, active low; clears windows, sums, stored GNSS variance and
// restores register defaults. Sample stores need no clearing.

module sliding_window_variance_gate #(
  parameter int WINDOW_DEPTH = 64,
  parameter int POS_WIDTH    = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  swvg_in_if.sink    in_chan,
  swvg_out_if.source out_chan,
  swvg_cfg_if.sink   cfg_chan
);
  import swvg_pkg::*;

  cfg_t       cfg_r;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_len     <= RST_WINDOW_LEN;
      cfg_r.gnss_var_limit <= RST_GNSS_VAR_LIMIT;
      cfg_r.odom_var_ratio <= RST_ODOM_VAR_RATIO;
      cfg_r.gnss_enable    <= 1'b1;
      cfg_r.odom_enable    <= 1'b1;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_WINDOW_LEN:     cfg_r.window_len     <= cfg_chan.data[LEN_W-1:0];
        CFG_GNSS_VAR_LIMIT: cfg_r.gnss_var_limit <= cfg_chan.data[LIMIT_W-1:0];
        CFG_ODOM_VAR_RATIO: cfg_r.odom_var_ratio <= cfg_chan.data[RATIO_W-1:0];
        CFG_GNSS_ENABLE:    cfg_r.gnss_enable    <= cfg_chan.data[0];
        CFG_ODOM_ENABLE:    cfg_r.odom_enable    <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  swvg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swvg_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .POS_WIDTH(POS_WIDTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .status          (status),
    .in_cmd          (in_chan.cmd),
    .in_pos_x        (in_chan.pos_x),
    .in_pos_y        (in_chan.pos_y),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_source_kind (out_chan.source_kind),
    .out_accepted    (out_chan.accepted),
    .out_window_ok   (out_chan.window_ok),
    .out_var_x       (out_chan.var_x_out),
    .out_var_y       (out_chan.var_y_out),
    .out_fill_count  (out_chan.fill_count)
  );

endmodule

### test/sliding_window_variance_gate_tb.sv
`timescale 1ns / 1ps

module sliding_window_variance_gate_tb;
  import swvg_pkg::*;

  localparam int DEPTH = 64;
  localparam int PW = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic             source_kind;
    logic             accepted;
    logic             window_ok;
    logic [VAR_W-1:0] var_x;
    logic [VAR_W-1:0] var_y;
    logic [FILL_W-1:0] fill;
  } gate_result_t;

  class variance_scoreboard;
    logic [LEN_W-1:0]   win_len;
    logic [LIMIT_W-1:0] var_limit;
    logic [RATIO_W-1:0] var_ratio;
    logic               en[2];
    longint             xs[2][DEPTH];
    longint             ys[2][DEPTH];
    int                 cnt[2];
    int                 head[2];
    longint             sum[4];
    longint unsigned    sqsum[4];
    longint unsigned    gnss_var[2];
    gate_result_t       pending[$];
    string              msg;

    function new();
      win_len = RST_WINDOW_LEN;
      var_limit = RST_GNSS_VAR_LIMIT;
      var_ratio = RST_ODOM_VAR_RATIO;
      en[0] = 1; en[1] = 1;
      for (int i = 0; i < 2; i++) begin
        cnt[i] = 0; head[i] = 0; gnss_var[i] = 0;
      end
      for (int i = 0; i < 4; i++) begin
        sum[i] = 0; sqsum[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_WINDOW_LEN: win_len = d[LEN_W-1:0];
        CFG_GNSS_VAR_LIMIT: var_limit = d[LIMIT_W-1:0];
        CFG_ODOM_VAR_RATIO: var_ratio = d[RATIO_W-1:0];
        CFG_GNSS_ENABLE: en[0] = d[0];
        CFG_ODOM_ENABLE: en[1] = d[0];
        default: ;
      endcase
    endfunction

    function longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned variance(int n, longint s1, longint unsigned s2);
      longint unsigned m, sq, num, q;
      if (n == 0) return 0;
      m = magnitude(s1);
      sq = m * m;
      num = longint'(n) * s2;
      if (sq >= num) return 0;
      q = (num - sq) / (longint'(n) * longint'(n));
      return q > VAR_MAX ? VAR_MAX : q;
    endfunction

    function void note(logic src, logic signed [PW-1:0] px, logic signed [PW-1:0] py);
      gate_result_t r;
      int s, len, idx, sx, sy;
      longint x, y;
      longint unsigned vx, vy;
      s = src;
      sx = 2 * s;
      sy = 2 * s + 1;
      r.source_kind = src;
      if (!en[s]) begin
        r.accepted = 0; r.window_ok = 0; r.var_x = 0; r.var_y = 0;
        r.fill = FILL_W'(cnt[s]);
        pending = {pending, r};
        return;
      end
      len = win_len;
      if (len == 0) len = 1;
      if (len > DEPTH) len = DEPTH;
      while (cnt[s] >= len && cnt[s] > 0) begin
        idx = (head[s] + DEPTH - cnt[s]) % DEPTH;
        sum[sx] -= xs[s][idx];
        sum[sy] -= ys[s][idx];
        sqsum[sx] -= magnitude(xs[s][idx]) * magnitude(xs[s][idx]);
        sqsum[sy] -= magnitude(ys[s][idx]) * magnitude(ys[s][idx]);
        cnt[s]--;
      end
      x = px;
      y = py;
      xs[s][head[s]] = x;
      ys[s][head[s]] = y;
      sum[sx] += x;
      sum[sy] += y;
      sqsum[sx] += magnitude(x) * magnitude(x);
      sqsum[sy] += magnitude(y) * magnitude(y);
      head[s] = (head[s] + 1) % DEPTH;
      cnt[s]++;
      vx = variance(cnt[s], sum[sx], sqsum[sx]);
      vy = variance(cnt[s], sum[sy], sqsum[sy]);
      if (src == SRC_GNSS) begin
        gnss_var[0] = vx;
        gnss_var[1] = vy;
        r.window_ok = (vx <= var_limit) && (vy <= var_limit);
      end else begin
        r.window_ok = 1;
        if (gnss_var[0] != 0 && gnss_var[1] != 0 &&
            (vx > longint'(var_ratio) * gnss_var[0] ||
             vy > longint'(var_ratio) * gnss_var[1]))
          r.window_ok = 0;
      end
      r.accepted = 1;
      r.var_x = VAR_W'(vx);
      r.var_y = VAR_W'(vy);
      r.fill = FILL_W'(cnt[s]);
      pending = {pending, r};
    endfunction

    function int check(gate_result_t got);
      gate_result_t e;
      if (pending.size() == 0) begin
        msg = "result transaction with nothing expected";
        return 1;
      end
      e = pending[0];
      pending.delete(0);
      msg = "";
      if (got.source_kind !== e.source_kind)
        msg = {msg, $sformatf(" source_kind %0d/%0d", got.source_kind, e.source_kind)};
      if (got.accepted !== e.accepted)
        msg = {msg, $sformatf(" accepted %0d/%0d", got.accepted, e.accepted)};
      if (got.window_ok !== e.window_ok)
        msg = {msg, $sformatf(" window_ok %0d/%0d", got.window_ok, e.window_ok)};
      if (got.var_x !== e.var_x)
        msg = {msg, $sformatf(" var_x %0d/%0d", got.var_x, e.var_x)};
      if (got.var_y !== e.var_y)
        msg = {msg, $sformatf(" var_y %0d/%0d", got.var_y, e.var_y)};
      if (got.fill !== e.fill)
        msg = {msg, $sformatf(" fill_count %0d/%0d", got.fill, e.fill)};
      return msg != "";
    endfunction
  endclass

  logic clk;
  logic rst_n;

  swvg_in_if #(.POS_WIDTH(PW)) in_chan ();
  swvg_out_if out_chan ();
  swvg_cfg_if cfg_chan ();

  sliding_window_variance_gate #(.WINDOW_DEPTH(DEPTH), .POS_WIDTH(PW)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  variance_scoreboard sb;
  int  errors = 0;
  int  n_results = 0;
  int  n_rejects = 0;
  int  n_fails = 0;
  int  n_cfg = 0;
  int  idle_cycles = 0;
  int  hold_cnt = 0;
  bit  no_idle = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 0;
    in_chan.valid = 0;
    in_chan.cmd = 0;
    in_chan.pos_x = 0;
    in_chan.pos_y = 0;
    out_chan.ready = 0;
    cfg_chan.valid = 0;
    cfg_chan.index = 0;
    cfg_chan.data = 0;
  end

  task automatic report(string text);
    $display("MISMATCH at %0t:%s", $realtime, text);
    errors++;
  endtask

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_chan.ready <= 0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      hold_cnt <= pick_gap();
      out_chan.ready <= 0;
    end else begin
      out_chan.ready <= 1;
    end
  end

  always @(posedge clk) begin
    gate_result_t got;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note(in_chan.cmd, in_chan.pos_x, in_chan.pos_y);
      if (out_chan.valid && out_chan.ready) begin
        got.source_kind = out_chan.source_kind;
        got.accepted = out_chan.accepted;
        got.window_ok = out_chan.window_ok;
        got.var_x = out_chan.var_x_out;
        got.var_y = out_chan.var_y_out;
        got.fill = out_chan.fill_count;
        n_results++;
        if (!got.accepted) n_rejects++;
        else if (!got.window_ok) n_fails++;
        if (sb.check(got)) report(sb.msg);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d results pending", sb.pending.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_sample(logic src, logic signed [PW-1:0] x, logic signed [PW-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.cmd <= src;
    in_chan.pos_x <= x;
    in_chan.pos_y <= y;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain();
    in_chan.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_chan.valid <= 1;
    cfg_chan.index <= idx;
    cfg_chan.data <= d;
    do @(posedge clk); while (!cfg_chan.ready);
    sb.write_reg(idx, d);
    n_cfg++;
  endtask

  task automatic setup(int wl, int lim, int ratio, bit ge, bit oe);
    write_cfg(CFG_WINDOW_LEN, CFG_DATA_W'(wl));
    write_cfg(CFG_GNSS_VAR_LIMIT, CFG_DATA_W'(lim));
    write_cfg(CFG_ODOM_VAR_RATIO, CFG_DATA_W'(ratio));
    write_cfg(CFG_GNSS_ENABLE, CFG_DATA_W'(ge));
    write_cfg(CFG_ODOM_ENABLE, CFG_DATA_W'(oe));
    cfg_chan.valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [PW-1:0] near(int base, int spread);
    longint v;
    v = longint'(base) + $signed($urandom_range(0, 2 * spread)) - spread;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return PW'(v);
  endfunction

  initial begin
    int base_x, base_y, spread, wl, lim, ratio, items;
    bit ge, oe;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_sample(SRC_ODOM, 24'sd100, -24'sd100);
    send_sample(SRC_GNSS, 24'sd0, 24'sd0);
    send_sample(SRC_GNSS, 24'sd80, -24'sd80);
    send_sample(SRC_GNSS, -24'sd80, 24'sd80);
    send_sample(SRC_ODOM, 24'sd5000, 24'sd0);
    send_sample(SRC_ODOM, -24'sd5000, 24'sd7);
    send_sample(SRC_GNSS, 24'h7FFFFF, 24'h800000);
    send_sample(SRC_GNSS, 24'h800000, 24'h7FFFFF);
    send_sample(SRC_ODOM, 24'h7FFFFF, 24'h7FFFFF);
    send_sample(SRC_ODOM, 24'h800000, 24'h800000);
    drain();
    setup(64, 24'hFFFFFF, 0, 1, 1);
    for (int i = 0; i < 6; i++)
      send_sample(1'(i % 2), (i % 2) ? 24'h800000 : 24'h7FFFFF, PW'(3 * i));
    drain();
    write_cfg(CFG_UNUSED_IDX, 24'hFFFFFF);
    setup(3, 0, 1023, 0, 1);
    send_sample(SRC_GNSS, 24'sd1, 24'sd1);
    send_sample(SRC_ODOM, 24'sd1, 24'sd2);
    drain();
    setup(0, 6554, 1, 1, 0);
    send_sample(SRC_GNSS, 24'sd10, 24'sd20);
    send_sample(SRC_ODOM, 24'sd10, 24'sd20);
    drain();
    setup(127, 6554, 100, 1, 1);
    send_sample(SRC_GNSS, 24'sd10, 24'sd20);
    send_sample(SRC_ODOM, 24'sd30, 24'sd40);
    drain();

    for (int phase = 0; phase < 14; phase++) begin
      case (phase % 7)
        0: wl = 1;
        1: wl = 64;
        2: wl = $urandom_range(2, 8);
        3: wl = $urandom_range(65, 127);
        4: wl = 0;
        default: wl = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 4))
        0: lim = 0;
        1: lim = 24'hFFFFFF;
        2: lim = RST_GNSS_VAR_LIMIT;
        default: lim = $urandom_range(0, 24'hFFFFFF);
      endcase
      case ($urandom_range(0, 4))
        0: ratio = 0;
        1: ratio = 1;
        2: ratio = 1023;
        default: ratio = $urandom_range(0, 1023);
      endcase
      ge = $urandom_range(0, 5) != 0;
      oe = $urandom_range(0, 5) != 0;
      no_idle = (phase % 5 == 2);
      setup(wl, lim, ratio, ge, oe);
      base_x = $signed($urandom());
      base_y = $signed($urandom());
      base_x = base_x >>> 8;
      base_y = base_y >>> 8;
      items = 105;
      for (int i = 0; i < items; i++) begin
        case ($urandom_range(0, 7))
          0: spread = 0;
          1: spread = 8388607;
          2: spread = $urandom_range(1000, 200000);
          default: spread = $urandom_range(1, 150);
        endcase
        if (spread == 8388607)
          send_sample(1'($urandom_range(0, 1)), PW'($urandom()), PW'($urandom()));
        else
          send_sample(1'($urandom_range(0, 1)), near(base_x, spread), near(base_y, spread));
      end
      drain();
    end
    no_idle = 0;

    repeat (400) @(posedge clk);
    if (sb.pending.size() != 0) report("expected results never arrived");
    $display("Covered %0d results (%0d from disabled sources, %0d failing the gate)",
             n_results, n_rejects, n_fails);
    $display("Register writes: %0d over 14 random settings plus directed corners", n_cfg);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
